// ===== src/motion_activated_click_mode_core_assert.svh =====
// assertion helpers for the click mode rtl
`ifndef MOTION_ACTIVATED_CLICK_MODE_CORE_ASSERT_SVH
`define MOTION_ACTIVATED_CLICK_MODE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MAC_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("click mode assertion failed");

// next-cycle implication, checked out of reset
`define MAC_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("click mode assertion failed");

`endif

// ===== src/mac_pkg.sv =====
package mac_pkg;

    // mode machine, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE      = 5'b00001,
        MODE_WAITING   = 5'b00010,
        MODE_CLICKABLE = 5'b00100,
        MODE_CLICKING  = 5'b01000,
        MODE_CLICKED   = 5'b10000
    } mode_t;

    // encoded mode as reported on the result word
    localparam logic [2:0] CODE_IDLE      = 3'd0;
    localparam logic [2:0] CODE_WAITING   = 3'd1;
    localparam logic [2:0] CODE_CLICKABLE = 3'd2;
    localparam logic [2:0] CODE_CLICKING  = 3'd3;
    localparam logic [2:0] CODE_CLICKED   = 3'd4;

    // item op codes
    localparam logic [1:0] OP_POINTER = 2'd0;
    localparam logic [1:0] OP_SENSOR  = 2'd1;
    localparam logic [1:0] OP_KEY     = 2'd2;

    // layer event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_ENABLE  = 2'd1;
    localparam logic [1:0] EV_DISABLE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICKABLE_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAITING_TIMEOUT   = 2'd2;

    // configuration reset values
    localparam logic [14:0] THRESHOLD_RST         = 15'd50;
    localparam logic [15:0] CLICKABLE_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] WAITING_TIMEOUT_RST   = 16'd50;

    localparam logic [14:0] SUM_MAX = 15'h7fff;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [15:0]        now_ms;
        logic               key_pressed;
        logic               key_is_noop;
        logic               key_transparent;
    } in_item_t;

    typedef struct packed {
        logic [2:0] mode_state;
        logic       click_layer_on;
        logic [1:0] layer_event;
    } out_item_t;

    typedef struct packed {
        logic [14:0] move_limit;
        logic [15:0] clickable_timeout_ms;
        logic [15:0] waiting_timeout_ms;
    } cfg_t;

    // magnitude of a 16-bit two's complement value, 32768 included
    function automatic logic [16:0] abs16(input logic [15:0] v);
        if (v[15])
            return 17'h10000 - {1'b0, v};
        return {1'b0, v};
    endfunction

    // add a motion amount to the sum, clamped at the 15-bit limit
    function automatic logic [14:0] sat_add(input logic [14:0] a, input logic [16:0] b);
        logic [17:0] s;
        s = {3'b000, a} + {1'b0, b};
        if (s > {3'b000, SUM_MAX})
            return SUM_MAX;
        return s[14:0];
    endfunction

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        unique case (m)
            MODE_IDLE:      c = CODE_IDLE;
            MODE_WAITING:   c = CODE_WAITING;
            MODE_CLICKABLE: c = CODE_CLICKABLE;
            MODE_CLICKING:  c = CODE_CLICKING;
            MODE_CLICKED:   c = CODE_CLICKED;
            default:        c = CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== src/mac_cfg.sv =====
module mac_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mac_pkg::cfg_t                    cfg
);

    logic [14:0] threshold_reg;
    logic [15:0] clickable_timeout_reg;
    logic [15:0] waiting_timeout_reg;

    // register writes, unused index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg         <= mac_pkg::THRESHOLD_RST;
            clickable_timeout_reg <= mac_pkg::CLICKABLE_TIMEOUT_RST;
            waiting_timeout_reg   <= mac_pkg::WAITING_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mac_pkg::CFG_THRESHOLD:         threshold_reg         <= cfg_data[14:0];
                mac_pkg::CFG_CLICKABLE_TIMEOUT: clickable_timeout_reg <= cfg_data;
                mac_pkg::CFG_WAITING_TIMEOUT:   waiting_timeout_reg   <= cfg_data;
                default:                        ;
            endcase
        end
    end

    assign cfg.move_limit           = threshold_reg;
    assign cfg.clickable_timeout_ms = clickable_timeout_reg;
    assign cfg.waiting_timeout_ms   = waiting_timeout_reg;

endmodule

// ===== src/mac_fsm.sv =====
`include "motion_activated_click_mode_core_assert.svh"

module mac_fsm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  mac_pkg::in_item_t    item,
    input  mac_pkg::cfg_t        cfg,
    output mac_pkg::out_item_t   result
);

    mac_pkg::mode_t mode_reg, mode_next;
    logic [14:0]    motion_sum_reg, motion_sum_next;
    logic [15:0]    time_stamp_reg, time_stamp_next;
    logic           layer_active_reg, layer_active_next;
    logic [1:0]     event_next;

    logic [16:0] amount;
    logic        moved;
    logic [14:0] sum_acc;
    logic [14:0] sum_new;
    logic [15:0] elapsed;
    logic        in_click;

    // motion magnitude and timing terms
    assign amount   = mac_pkg::abs16(item.dx) + mac_pkg::abs16(item.dy);
    assign moved    = (item.dx != 16'sd0) || (item.dy != 16'sd0);
    assign sum_acc  = mac_pkg::sat_add(motion_sum_reg, amount);
    assign sum_new  = mac_pkg::sat_add(15'd0, amount);
    assign elapsed  = item.now_ms - time_stamp_reg;
    assign in_click = (mode_reg == mac_pkg::MODE_CLICKABLE) ||
                      (mode_reg == mac_pkg::MODE_CLICKING) ||
                      (mode_reg == mac_pkg::MODE_CLICKED);

    // next state for the word in flight
    always_comb
    begin
        mode_next         = mode_reg;
        motion_sum_next   = motion_sum_reg;
        time_stamp_next   = time_stamp_reg;
        layer_active_next = layer_active_reg;
        event_next        = mac_pkg::EV_NONE;
        unique case (item.op)
            mac_pkg::OP_POINTER:
            begin
                if (moved)
                begin
                    unique case (mode_reg) inside
                        mac_pkg::MODE_WAITING:
                        begin
                            if (sum_acc >= cfg.move_limit)
                            begin
                                motion_sum_next   = 15'd0;
                                layer_active_next = 1'b1;
                                time_stamp_next   = item.now_ms;
                                mode_next         = mac_pkg::MODE_CLICKABLE;
                                event_next        = mac_pkg::EV_ENABLE;
                            end
                            else
                                motion_sum_next = sum_acc;
                        end
                        mac_pkg::MODE_CLICKABLE: time_stamp_next = item.now_ms;
                        mac_pkg::MODE_CLICKING,
                        mac_pkg::MODE_CLICKED:   ;
                        default:
                        begin
                            time_stamp_next = item.now_ms;
                            mode_next       = mac_pkg::MODE_WAITING;
                            motion_sum_next = sum_new;
                        end
                    endcase
                end
                else
                begin
                    // idle poll: timeouts and return from clicked
                    unique case (mode_reg)
                        mac_pkg::MODE_WAITING:
                        begin
                            if (elapsed > cfg.waiting_timeout_ms)
                            begin
                                motion_sum_next = 15'd0;
                                mode_next       = mac_pkg::MODE_IDLE;
                            end
                        end
                        mac_pkg::MODE_CLICKABLE:
                        begin
                            if (elapsed > cfg.clickable_timeout_ms)
                            begin
                                mode_next         = mac_pkg::MODE_IDLE;
                                layer_active_next = 1'b0;
                                motion_sum_next   = 15'd0;
                                event_next        = mac_pkg::EV_DISABLE;
                            end
                        end
                        mac_pkg::MODE_CLICKING: ;
                        mac_pkg::MODE_CLICKED:
                        begin
                            mode_next       = mac_pkg::MODE_CLICKABLE;
                            time_stamp_next = item.now_ms;
                        end
                        default:
                        begin
                            motion_sum_next = 15'd0;
                            mode_next       = mac_pkg::MODE_IDLE;
                        end
                    endcase
                end
            end
            mac_pkg::OP_SENSOR:
            begin
                if (moved)
                begin
                    unique case (mode_reg) inside
                        mac_pkg::MODE_IDLE:
                        begin
                            mode_next       = mac_pkg::MODE_WAITING;
                            time_stamp_next = item.now_ms;
                            motion_sum_next = sum_new;
                        end
                        mac_pkg::MODE_WAITING:
                        begin
                            // sum is kept on this path when the layer turns on
                            motion_sum_next = sum_acc;
                            if (sum_acc >= cfg.move_limit)
                            begin
                                layer_active_next = 1'b1;
                                time_stamp_next   = item.now_ms;
                                mode_next         = mac_pkg::MODE_CLICKABLE;
                                event_next        = mac_pkg::EV_ENABLE;
                            end
                        end
                        mac_pkg::MODE_CLICKABLE,
                        mac_pkg::MODE_CLICKED:
                        begin
                            mode_next       = mac_pkg::MODE_CLICKABLE;
                            time_stamp_next = item.now_ms;
                        end
                        default: ;
                    endcase
                end
            end
            mac_pkg::OP_KEY:
            begin
                if (in_click)
                begin
                    if (item.key_pressed)
                    begin
                        if (item.key_is_noop || item.key_transparent)
                        begin
                            mode_next         = mac_pkg::MODE_IDLE;
                            layer_active_next = 1'b0;
                            motion_sum_next   = 15'd0;
                            event_next        = mac_pkg::EV_DISABLE;
                        end
                        else
                            mode_next = mac_pkg::MODE_CLICKING;
                    end
                    else if (mode_reg == mac_pkg::MODE_CLICKING)
                    begin
                        mode_next       = mac_pkg::MODE_CLICKED;
                        time_stamp_next = item.now_ms;
                    end
                end
            end
            default: ;
        endcase
    end

    // state registers advance once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= mac_pkg::MODE_IDLE;
            motion_sum_reg   <= 15'd0;
            time_stamp_reg   <= 16'd0;
            layer_active_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            motion_sum_reg   <= motion_sum_next;
            time_stamp_reg   <= time_stamp_next;
            layer_active_reg <= layer_active_next;
        end
    end

    // result for the word in flight
    assign result.mode_state     = mac_pkg::mode_code(mode_next);
    assign result.click_layer_on = layer_active_next;
    assign result.layer_event    = event_next;

    // layer flag tracks the click states
    `MAC_ASSERT_NOW(a_layer_matches_mode, clk, rst_n, 1'b1, layer_active_reg == in_click)
    // idle never holds a motion sum
    `MAC_ASSERT_NOW(a_idle_sum_clear, clk, rst_n, mode_reg == mac_pkg::MODE_IDLE,
        motion_sum_reg == 15'd0)
    // enable event lands in clickable with the stamp taken
    `MAC_ASSERT_NEXT(a_enable_clickable, clk, rst_n,
        fire && (event_next == mac_pkg::EV_ENABLE),
        (mode_reg == mac_pkg::MODE_CLICKABLE) && (time_stamp_reg == $past(item.now_ms)))
    // disable event returns to idle
    `MAC_ASSERT_NEXT(a_disable_idle, clk, rst_n,
        fire && (event_next == mac_pkg::EV_DISABLE),
        (mode_reg == mac_pkg::MODE_IDLE) && !layer_active_reg)

endmodule

// ===== src/motion_activated_click_mode_core.sv =====
// Motion-activated click mode controller. Each input word (pointer report or
// poll, sensor motion, or key event, stamped with a 16-bit millisecond time)
// produces exactly one result word carrying the mode, the click layer flag and
// any layer enable/disable event. A word is registered on entry, the mode
// machine updates from the input register, and the result is registered on
// exit. A new word is taken every cycle while the output does not stall; the
// combinational state update between the input and result registers sets
// that rate. Stall on the output holds the result register and, once the input
// register is also full, raises the input stall. Configuration writes take
// effect at once and are meant only while no word is in flight.
module motion_activated_click_mode_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mac_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mac_pkg::out_item_t               out_data,
    input  logic                             cfg_we,
    input  logic [mac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mac_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    mac_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    mac_pkg::cfg_t      cfg;
    mac_pkg::out_item_t result;
    logic               out_ready;
    logic               fire;
    logic               in_take;

    // handshake between the two register stages
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign in_take   = in_valid && !in_stall;

    mac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mac_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_take || (in_valid_reg && !fire);
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
